// ----- hw/rtl/macd_pkg.sv -----
// Package: widths, register codes, reset values and shared types of the MACD core.
package macd_pkg;

  localparam int PRICE_W    = 32;
  localparam int EXTRA_W    = 16;
  localparam int ALPHA_W    = 16;
  localparam int AVG_W      = PRICE_W + EXTRA_W;
  localparam int SIG_W      = AVG_W + 1;
  localparam int DELTA_W    = AVG_W + 2;
  localparam int CHUNK_W    = DELTA_W / 2;
  localparam int OPND_W     = DELTA_W - CHUNK_W + 1;
  localparam int PROD_W     = OPND_W + ALPHA_W + 1;
  localparam int ACC_W      = DELTA_W + ALPHA_W + 1;
  localparam int MACD_OUT_W = PRICE_W + 1;
  localparam int HIST_OUT_W = PRICE_W + 2;
  localparam int CFG_IDX_W  = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_ALPHA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_ALPHA   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_ALPHA = 2'd2;

  localparam logic [ALPHA_W-1:0] SHORT_ALPHA_RST  = 16'd10082;
  localparam logic [ALPHA_W-1:0] LONG_ALPHA_RST   = 16'd4855;
  localparam logic [ALPHA_W-1:0] SIGNAL_ALPHA_RST = 16'd13107;

  // average select codes
  localparam logic [1:0] SEL_SHORT  = 2'd0;
  localparam logic [1:0] SEL_LONG   = 2'd1;
  localparam logic [1:0] SEL_SIGNAL = 2'd2;

  typedef struct packed {
    logic [ALPHA_W-1:0] short_alpha;
    logic [ALPHA_W-1:0] long_alpha;
    logic [ALPHA_W-1:0] signal_alpha;
  } alpha_set_t;

  typedef struct packed {
    logic       load;
    logic       seed;
    logic       delta;
    logic       mul_lo;
    logic       mul_hi;
    logic       update;
    logic       macd;
    logic       result;
    logic [1:0] sel;
  } dp_cmd_t;

  typedef struct packed {
    logic first;
  } dp_status_t;

endpackage

// ----- hw/rtl/macd_if.sv -----
// Interfaces: price item channel, result item channel and register write channel.
interface macd_in_if;
  logic                         valid;
  logic                         ready;
  logic [macd_pkg::PRICE_W-1:0] close_price;
  logic                         first_of_series;

  modport source (output valid, close_price, first_of_series, input ready);
  modport sink (input valid, close_price, first_of_series, output ready);
endinterface

interface macd_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [macd_pkg::MACD_OUT_W-1:0] macd_value;
  logic signed [macd_pkg::MACD_OUT_W-1:0] signal_value;
  logic signed [macd_pkg::HIST_OUT_W-1:0] histogram_value;

  modport source (output valid, macd_value, signal_value, histogram_value, input ready);
  modport sink (input valid, macd_value, signal_value, histogram_value, output ready);
endinterface

interface macd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [macd_pkg::CFG_IDX_W-1:0] index;
  logic [macd_pkg::ALPHA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/macd_cfg.sv -----
// Smoothing factor registers written over the configuration channel.
module macd_cfg (
  input  logic                 clk,
  input  logic                 rst,
  macd_cfg_if.sink             cfg,
  output macd_pkg::alpha_set_t alphas
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphas.short_alpha  <= macd_pkg::SHORT_ALPHA_RST;
      alphas.long_alpha   <= macd_pkg::LONG_ALPHA_RST;
      alphas.signal_alpha <= macd_pkg::SIGNAL_ALPHA_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        macd_pkg::REG_SHORT_ALPHA:  alphas.short_alpha  <= cfg.data;
        macd_pkg::REG_LONG_ALPHA:   alphas.long_alpha   <= cfg.data;
        macd_pkg::REG_SIGNAL_ALPHA: alphas.signal_alpha <= cfg.data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

endmodule

// ----- hw/rtl/macd_dp.sv -----
// Datapath: averages, shared split multiplier, accumulator and result registers.
module macd_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  macd_pkg::dp_cmd_t                     cmd,
  input  macd_pkg::alpha_set_t                  alphas,
  input  logic [macd_pkg::PRICE_W-1:0]          close_price,
  input  logic                                  first_of_series,
  output macd_pkg::dp_status_t                  status,
  output logic signed [macd_pkg::MACD_OUT_W-1:0] macd_value,
  output logic signed [macd_pkg::MACD_OUT_W-1:0] signal_value,
  output logic signed [macd_pkg::HIST_OUT_W-1:0] histogram_value
);

  logic [macd_pkg::PRICE_W-1:0]        price;
  logic                                first;
  logic [macd_pkg::AVG_W-1:0]          short_avg;
  logic [macd_pkg::AVG_W-1:0]          long_avg;
  logic signed [macd_pkg::SIG_W-1:0]   signal_avg;
  logic signed [macd_pkg::SIG_W-1:0]   macd;
  logic signed [macd_pkg::DELTA_W-1:0] delta;
  logic signed [macd_pkg::ACC_W-1:0]   acc;

  logic [macd_pkg::AVG_W-1:0]          price_q;
  logic signed [macd_pkg::DELTA_W-1:0] delta_next;
  logic [macd_pkg::ALPHA_W-1:0]        alpha_cur;
  logic signed [macd_pkg::OPND_W-1:0]  opnd;
  logic signed [macd_pkg::PROD_W-1:0]  prod;
  logic signed [macd_pkg::DELTA_W-1:0] step;
  logic signed [macd_pkg::DELTA_W-1:0] hist_full;

  assign status.first = first;
  assign price_q = {price, {macd_pkg::EXTRA_W{1'b0}}};

  always_comb begin
    case (cmd.sel)
      macd_pkg::SEL_SHORT: begin
        delta_next = $signed({2'b00, price_q}) - $signed({2'b00, short_avg});
        alpha_cur  = alphas.short_alpha;
      end
      macd_pkg::SEL_LONG: begin
        delta_next = $signed({2'b00, price_q}) - $signed({2'b00, long_avg});
        alpha_cur  = alphas.long_alpha;
      end
      default: begin
        delta_next = macd_pkg::DELTA_W'(macd) - macd_pkg::DELTA_W'(signal_avg);
        alpha_cur  = alphas.signal_alpha;
      end
    endcase
  end

  // low chunk unsigned, high chunk carries the sign
  always_comb begin
    if (cmd.mul_hi) begin
      opnd = macd_pkg::OPND_W'($signed(delta[macd_pkg::DELTA_W-1:macd_pkg::CHUNK_W]));
    end else begin
      opnd = $signed({{(macd_pkg::OPND_W - macd_pkg::CHUNK_W){1'b0}},
                      delta[macd_pkg::CHUNK_W-1:0]});
    end
  end

  assign prod      = opnd * $signed({1'b0, alpha_cur});
  assign step      = acc[macd_pkg::ALPHA_W +: macd_pkg::DELTA_W];
  assign hist_full = macd_pkg::DELTA_W'(macd) - macd_pkg::DELTA_W'(signal_avg);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      price <= close_price;
      first <= first_of_series;
    end
    if (cmd.delta) begin
      delta <= delta_next;
    end
    if (cmd.mul_lo) begin
      acc <= macd_pkg::ACC_W'(prod);
    end else if (cmd.mul_hi) begin
      acc <= acc + (macd_pkg::ACC_W'(prod) <<< macd_pkg::CHUNK_W);
    end
    if (cmd.result) begin
      macd_value      <= macd[macd_pkg::SIG_W-1:macd_pkg::EXTRA_W];
      signal_value    <= signal_avg[macd_pkg::SIG_W-1:macd_pkg::EXTRA_W];
      histogram_value <= hist_full[macd_pkg::DELTA_W-1:macd_pkg::EXTRA_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_avg  <= '0;
      long_avg   <= '0;
      signal_avg <= '0;
      macd       <= '0;
    end else if (cmd.seed) begin
      short_avg  <= price_q;
      long_avg   <= price_q;
      signal_avg <= '0;
      macd       <= '0;
    end else begin
      if (cmd.update) begin
        case (cmd.sel)
          macd_pkg::SEL_SHORT: short_avg  <= short_avg + step[macd_pkg::AVG_W-1:0];
          macd_pkg::SEL_LONG:  long_avg   <= long_avg + step[macd_pkg::AVG_W-1:0];
          default:             signal_avg <= signal_avg + step[macd_pkg::SIG_W-1:0];
        endcase
      end
      if (cmd.macd) begin
        macd <= $signed({1'b0, short_avg}) - $signed({1'b0, long_avg});
      end
    end
  end

endmodule

// ----- hw/rtl/macd_ctrl.sv -----
// Controller: sequences delta, two multiply passes and update for each average; a series start is seeded instead.
module macd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  macd_pkg::dp_status_t status,
  output macd_pkg::dp_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DELTA  = 3'd1;
  localparam logic [2:0] ST_MUL_LO = 3'd2;
  localparam logic [2:0] ST_MUL_HI = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;
  localparam logic [2:0] ST_MACD   = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] sel;
  logic [1:0] sel_next;
  logic       out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    sel_next       = sel;
    cmd            = '0;
    cmd.sel        = sel;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          sel_next   = macd_pkg::SEL_SHORT;
          state_next = ST_DELTA;
        end
      end
      ST_DELTA: begin
        if (sel == macd_pkg::SEL_SHORT && status.first) begin
          cmd.seed   = 1'b1;
          state_next = ST_OUT;
        end else begin
          cmd.delta  = 1'b1;
          state_next = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        if (sel == macd_pkg::SEL_SHORT) begin
          sel_next   = macd_pkg::SEL_LONG;
          state_next = ST_DELTA;
        end else if (sel == macd_pkg::SEL_LONG) begin
          state_next = ST_MACD;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_MACD: begin
        cmd.macd   = 1'b1;
        sel_next   = macd_pkg::SEL_SIGNAL;
        state_next = ST_DELTA;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.result     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sel       <= macd_pkg::SEL_SHORT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sel       <= sel_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- hw/rtl/macd_indicator_core.sv -----
// Top level of the MACD core: register block, controller and datapath.
// An accepted price item is worked through to its result item before the next
// is taken; an item that starts a series only seeds the averages. The one
// shared 26x17 multiplier takes two passes for each of the three averages.
// Reset (rst, synchronous): averages and signal line clear, default alphas, no result.
module macd_indicator_core (
  input  logic       clk,
  input  logic       rst,
  macd_in_if.sink    price,
  macd_out_if.source result,
  macd_cfg_if.sink   cfg
);

  macd_pkg::alpha_set_t alphas;
  macd_pkg::dp_cmd_t    cmd;
  macd_pkg::dp_status_t status;

  // Config regs, always ready; writes must land while the core is idle (unenforced).
  macd_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .alphas (alphas)
  );

  // Sequencer. A new price item is taken only from idle; a finished result
  // sits in the output register while the next item is already in flight.
  macd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (price.valid),
    .in_ready  (price.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Each average step: delta = target - avg, product = delta * alpha built from
  // a low (unsigned) and a high (signed) half, avg += floor(product / 2^16).
  macd_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .alphas          (alphas),
    .close_price     (price.close_price),
    .first_of_series (price.first_of_series),
    .status          (status),
    .macd_value      (result.macd_value),
    .signal_value    (result.signal_value),
    .histogram_value (result.histogram_value)
  );

  // An accepted item puts the core to work, so it refuses the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    price.valid && price.ready |=> !price.ready)
    else $error("input taken twice in a row");

  // A new result never overwrites one that has not been taken.
  assert property (@(posedge clk) disable iff (rst)
    cmd.result |-> (!result.valid || result.ready))
    else $error("pending result overwritten");

  // A written result is offered in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    cmd.result |=> result.valid)
    else $error("result written but not offered");

  // Datapath commands are exclusive.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.seed, cmd.delta, cmd.mul_lo, cmd.mul_hi,
              cmd.update, cmd.macd, cmd.result}))
    else $error("overlapping datapath commands");

endmodule

// ----- sim/tb.sv -----
// Testbench for the MACD indicator core: predicted results checked item by item.
`timescale 1ns / 1ps

module tb;

  // Run limits. IDLE_PAD pads the wait for every owed result to come out before
  // a register write.
  localparam int IDLE_PAD     = 24;
  localparam int HOLD_CYCLES  = 400;   // long output hold-off of the pressure test
  localparam int STALL_LIMIT  = 3000;  // cycles with no handshake before giving up
  localparam int MAX_REPORTS  = 40;    // printed mismatch lines, all are counted

  // One result item as the core should emit it.
  typedef struct packed {
    logic signed [macd_pkg::MACD_OUT_W-1:0] macd;
    logic signed [macd_pkg::MACD_OUT_W-1:0] signal;
    logic signed [macd_pkg::HIST_OUT_W-1:0] hist;
  } macd_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  macd_in_if  price_if ();
  macd_out_if result_if ();
  macd_cfg_if cfg_if ();

  macd_indicator_core dut (
    .clk    (clk),
    .rst    (rst),
    .price  (price_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  // 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: its own copy of the three averages (Q.16, held in 64 bits) and
  // of the smoothing factors. Updated once per accepted item, in accept order.
  // ---------------------------------------------------------------------------
  logic [macd_pkg::ALPHA_W-1:0] short_alpha_q  = macd_pkg::SHORT_ALPHA_RST;
  logic [macd_pkg::ALPHA_W-1:0] long_alpha_q   = macd_pkg::LONG_ALPHA_RST;
  logic [macd_pkg::ALPHA_W-1:0] signal_alpha_q = macd_pkg::SIGNAL_ALPHA_RST;
  longint short_ema  = 0;
  longint long_ema   = 0;
  longint signal_ema = 0;

  macd_result_t pending_macd[$];   // results owed by the core, oldest first

  int items_sent     = 0;
  int results_seen   = 0;
  int alpha_writes   = 0;
  int mismatches     = 0;
  int burst_left     = 0;          // items left in the current sender burst
  int hold_requests  = 0;          // raised by the pressure test
  int holds_served   = 0;          // owned by the receiver process
  int hold_left      = 0;
  int rcv_cycle      = 0;
  int quiet_cycles   = 0;

  // avg moves toward target by floor((target - avg) * alpha / 2^ALPHA_W).
  // The delta is split so the product never leaves 64 bits.
  function automatic longint ema_move(longint avg, longint target,
                                      logic [macd_pkg::ALPHA_W-1:0] alpha);
    longint delta;
    longint hi;
    longint lo;
    longint a;
    delta = target - avg;
    hi    = delta >>> macd_pkg::ALPHA_W;
    lo    = delta - (hi <<< macd_pkg::ALPHA_W);   // 0 .. 2^ALPHA_W - 1
    a     = longint'({48'd0, alpha});
    return avg + hi * a + ((lo * a) >>> macd_pkg::ALPHA_W);
  endfunction

  // Advance the predicted state by one price item and return the result item.
  function automatic macd_result_t predict_macd(logic [macd_pkg::PRICE_W-1:0] px,
                                                logic first);
    macd_result_t r;
    longint target;
    longint macd_full;
    longint q;
    target = longint'({32'd0, px}) <<< macd_pkg::EXTRA_W;
    if (first) begin
      // series start seeds both averages and clears the signal line
      short_ema  = target;
      long_ema   = target;
      signal_ema = 0;
    end else begin
      short_ema = ema_move(short_ema, target, short_alpha_q);
      long_ema  = ema_move(long_ema, target, long_alpha_q);
    end
    macd_full = short_ema - long_ema;
    if (!first) begin
      signal_ema = ema_move(signal_ema, macd_full, signal_alpha_q);
    end
    // outputs drop the extra fraction bits with floor, then wrap to port width
    q        = macd_full >>> macd_pkg::EXTRA_W;
    r.macd   = q[macd_pkg::MACD_OUT_W-1:0];
    q        = signal_ema >>> macd_pkg::EXTRA_W;
    r.signal = q[macd_pkg::MACD_OUT_W-1:0];
    q        = (macd_full - signal_ema) >>> macd_pkg::EXTRA_W;
    r.hist   = q[macd_pkg::HIST_OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driving. All inputs are driven with NBAs right after a rising edge, and
  // handshakes are sampled at the edge, so nothing hinges on event order.
  // ---------------------------------------------------------------------------

  // Send one price item. The sender works in bursts; between bursts valid
  // drops for a random gap so gaps land on every phase of the core's work.
  task automatic send_price(logic [macd_pkg::PRICE_W-1:0] px, logic first);
    int gap;
    macd_result_t owed;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 18);
      price_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    price_if.valid           <= 1'b1;
    price_if.close_price     <= px;
    price_if.first_of_series <= first;
    do @(posedge clk); while (!price_if.ready);
    if (burst_left > 0) burst_left--;
    owed = predict_macd(px, first);
    pending_macd.insert(pending_macd.size(), owed);
    items_sent++;
  endtask

  // Stop offering items and let every owed result come out, plus a pad.
  task automatic wait_idle();
    price_if.valid <= 1'b0;
    while (pending_macd.size() != 0) @(posedge clk);
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  // Register write; only ever issued with the core idle.
  task automatic write_alpha(logic [macd_pkg::CFG_IDX_W-1:0] idx,
                             logic [macd_pkg::ALPHA_W-1:0] val);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      macd_pkg::REG_SHORT_ALPHA:  short_alpha_q  = val;
      macd_pkg::REG_LONG_ALPHA:   long_alpha_q   = val;
      macd_pkg::REG_SIGNAL_ALPHA: signal_alpha_q = val;
      default: ;
    endcase
    alpha_writes++;
  endtask

  task automatic write_alphas(logic [macd_pkg::ALPHA_W-1:0] s,
                              logic [macd_pkg::ALPHA_W-1:0] l,
                              logic [macd_pkg::ALPHA_W-1:0] g);
    write_alpha(macd_pkg::REG_SHORT_ALPHA, s);
    write_alpha(macd_pkg::REG_LONG_ALPHA, l);
    write_alpha(macd_pkg::REG_SIGNAL_ALPHA, g);
  endtask

  // Random smoothing factor, weighted toward the extremes (zero freezes).
  function automatic logic [macd_pkg::ALPHA_W-1:0] pick_alpha();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return macd_pkg::ALPHA_W'(1);
      2:       return '1;
      3:       return macd_pkg::ALPHA_W'($urandom_range(2, 600));
      default: return macd_pkg::ALPHA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // A series: a start item, then a random walk of prices with a random step
  // size. Some series are wild (full-range prices) and a few items break the
  // series with a stray start or a jump.
  task automatic send_series(int len);
    longint px;
    longint step;
    int k;
    bit wild;
    logic first;
    wild = ($urandom_range(0, 5) == 0);
    step = longint'(1) << $urandom_range(2, 22);
    case ($urandom_range(0, 3))
      0:       px = $urandom_range(0, 1 << 16);
      1:       px = 64'hFFFF_FFFF - $urandom_range(0, 1 << 16);
      default: px = $urandom;
    endcase
    send_price(px[macd_pkg::PRICE_W-1:0], 1'b1);
    for (k = 1; k < len; k++) begin
      first = ($urandom_range(0, 24) == 0);
      if (wild || $urandom_range(0, 19) == 0) begin
        px = $urandom;
      end else begin
        px = px + longint'($urandom_range(0, 2 * step)) - step;
        if (px < 0) px = 0;
        if (px > 64'hFFFF_FFFF) px = 64'hFFFF_FFFF;
      end
      send_price(px[macd_pkg::PRICE_W-1:0], first);
    end
  endtask

  task automatic run_random_items(int n);
    int done;
    int len;
    done = 0;
    while (done < n) begin
      len = $urandom_range(8, 40);
      if (len > n - done) len = n - done;
      send_series(len);
      done += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // No series start yet: averages move from their zero reset values.
  task automatic test_no_start_after_reset();
    send_price(32'h0000_0100, 1'b0);
    send_price(32'hFFFF_FFFF, 1'b0);
    send_price(32'h0000_0000, 1'b0);
    send_price(32'hFFFF_FFFF, 1'b0);
  endtask

  // Start items seed the averages; full-scale swings in both directions.
  task automatic test_series_start();
    send_price(32'hFFFF_FFFF, 1'b1);
    send_price(32'h0000_0000, 1'b0);
    send_price(32'hFFFF_FFFF, 1'b0);
    send_price(32'h0000_0000, 1'b1);
    send_price(32'hFFFF_FFFF, 1'b0);
    send_price(32'h1234_5678, 1'b1);
  endtask

  // Full, unit and zero smoothing factors, then back to the defaults.
  task automatic test_alpha_extremes();
    write_alphas('1, '1, '1);
    send_price(32'h0000_0000, 1'b1);
    send_price(32'hFFFF_FFFF, 1'b0);
    send_price(32'h0000_0000, 1'b0);
    write_alphas(macd_pkg::ALPHA_W'(1), macd_pkg::ALPHA_W'(1), macd_pkg::ALPHA_W'(1));
    send_price(32'hFFFF_FFFF, 1'b1);
    send_price(32'h0000_0000, 1'b0);
    send_price(32'hFFFF_FFFF, 1'b0);
    write_alphas('0, '0, '0);     // frozen averages
    send_price(32'h0000_1000, 1'b0);
    send_price(32'hFFFF_FFFF, 1'b0);
    send_price(32'hABCD_EF01, 1'b1);
    send_price(32'h0000_0000, 1'b0);
    write_alphas(macd_pkg::SHORT_ALPHA_RST, macd_pkg::LONG_ALPHA_RST,
                 macd_pkg::SIGNAL_ALPHA_RST);
  endtask

  task automatic test_random_defaults();
    run_random_items(200);
  endtask

  // Output held off for a long stretch while the sender offers back to back,
  // so the core fills up and stalls its input.
  task automatic test_output_backpressure();
    wait_idle();
    burst_left    = 1000;
    hold_requests <= hold_requests + 1;
    run_random_items(60);
    burst_left    = 0;
  endtask

  // Several register settings, each followed by random series.
  task automatic test_random_alphas();
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      write_alphas(pick_alpha(), pick_alpha(), pick_alpha());
      run_random_items(65);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready pattern, long hold-off, result checking
  // ---------------------------------------------------------------------------

  // Ready cycles through four modes in turn: always ready, 3 of 5,
  // sparse random and dense random. A hold request overrides it.
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served    <= hold_requests;
      hold_left       <= HOLD_CYCLES;
      result_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left       <= hold_left - 1;
      result_if.ready <= 1'b0;
    end else begin
      rcv_cycle <= rcv_cycle + 1;
      case ((rcv_cycle / 97) % 4)
        0:       result_if.ready <= 1'b1;
        1:       result_if.ready <= ((rcv_cycle % 5) < 3);
        2:       result_if.ready <= ($urandom_range(0, 3) == 0);
        default: result_if.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Every accepted result is matched against the oldest owed result.
  always @(posedge clk) begin
    macd_result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_macd.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed: macd %0d",
                                  result_if.macd_value));
      end else begin
        want = pending_macd.pop_front();
        if (result_if.macd_value !== want.macd)
          report_mismatch($sformatf("result %0d macd_value %0d, want %0d",
                                    results_seen, result_if.macd_value, want.macd));
        if (result_if.signal_value !== want.signal)
          report_mismatch($sformatf("result %0d signal_value %0d, want %0d",
                                    results_seen, result_if.signal_value, want.signal));
        if (result_if.histogram_value !== want.hist)
          report_mismatch($sformatf("result %0d histogram_value %0d, want %0d",
                                    results_seen, result_if.histogram_value, want.hist));
      end
      results_seen++;
    end
  end

  // Watchdog: too long without any handshake on any channel means a hang.
  always @(posedge clk) begin
    if (rst || (price_if.valid && price_if.ready) ||
        (result_if.valid && result_if.ready) || (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    price_if.valid           = 1'b0;
    price_if.close_price     = '0;
    price_if.first_of_series = 1'b0;
    cfg_if.valid             = 1'b0;
    cfg_if.index             = macd_pkg::REG_SHORT_ALPHA;
    cfg_if.data              = '0;

    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_no_start_after_reset();
    test_series_start();
    test_alpha_extremes();
    test_random_defaults();
    test_output_backpressure();
    test_random_alphas();

    wait_idle();
    if (pending_macd.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_macd.size()));
    end

    $display("ran %0d price items, checked %0d results, %0d alpha writes, %0d mismatches",
             items_sent, results_seen, alpha_writes, mismatches);
    $display("covered cold start, series starts, zero/unit/full alphas, %0d-cycle hold",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
